>>> rtl/core/fsa_pkg.sv
// Package for the flocking steering accumulator.
// Widths, reset values and register indexes; no dependencies.
package fsa_pkg;
	localparam int MAX_NEIGHBOURS = 64;
	localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
	localparam int SUM_W = 48;
	localparam int ACC_W = 50;
	localparam int ADDR_W = 4;

	localparam logic [1:0] REG_SEP = 2'd0;
	localparam logic [1:0] REG_ALI = 2'd1;
	localparam logic [1:0] REG_COH = 2'd2;

	localparam logic [15:0] SEP_RADIUS_RST = 16'd200;
	localparam logic [15:0] ALI_RADIUS_RST = 16'd300;
	localparam logic [15:0] COH_RADIUS_RST = 16'd400;

	// squared tier bounds in whole units (80, 120, 200)
	localparam logic [31:0] TIER10_SQ = 32'd6400;
	localparam logic [31:0] TIER5_SQ = 32'd14400;
	localparam logic [31:0] TIER2_SQ = 32'd40000;
endpackage

>>> rtl/core/fsa_rec_if.sv
// Channel interfaces: neighbour record in, steering result out.
// Standalone; valid/ready handshake.
interface fsa_rec_if;
	logic valid;
	logic ready;
	logic signed [31:0] self_x, self_y, self_z;
	logic signed [31:0] other_px, other_py, other_pz;
	logic signed [31:0] other_vx, other_vy, other_vz;
	logic last_one;
	modport source(output valid, self_x, self_y, self_z, other_px, other_py, other_pz,
		other_vx, other_vy, other_vz, last_one, input ready);
	modport sink(input valid, self_x, self_y, self_z, other_px, other_py, other_pz,
		other_vx, other_vy, other_vz, last_one, output ready);
endinterface

interface fsa_res_if;
	logic valid;
	logic ready;
	logic signed [31:0] accel_x, accel_y, accel_z;
	modport source(output valid, accel_x, accel_y, accel_z, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, output ready);
endinterface

>>> rtl/core/flocking_steering_accumulator_top.sv
// Top level of the flocking steering accumulator.
// Uses fsa_pkg and the channel interfaces in fsa_rec_if.sv.
//
// channel   dir  beat
// rec       in   one neighbour record (self pos, other pos/vel, last_one)
// res       out  one steering acceleration, after the last record
// apb       in   radius registers at 0x0, 0x4, 0x8
//
// A record goes through capture, seven steps of the shared 32x32
// multiplier (three squared offsets, three squared radii), compare, three
// axis accumulations. Records beyond MAX_NEIGHBOURS are dropped; a last one still ends the set.
// The last record adds up to nine serial divides (load, bit-serial divide, sum)
// through the shared divider, then the output state, which waits while
// an earlier result is still not taken. Reset takes effect at once.
module flocking_steering_accumulator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	fsa_rec_if.sink                   rec,
	fsa_res_if.source                 res,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fsa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import fsa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_ACC   = 3'd3;
	localparam logic [2:0] ST_DLOAD = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DSUM  = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	localparam logic [1:0] W10 = 2'd0;
	localparam logic [1:0] W5  = 2'd1;
	localparam logic [1:0] W2  = 2'd2;
	localparam logic [1:0] W1  = 2'd3;

	localparam logic [1:0] GRP_SEP = 2'd0;
	localparam logic [1:0] GRP_ALI = 2'd1;
	localparam logic [1:0] GRP_COH = 2'd2;

	logic [2:0] state_q;
	logic [15:0] radius_q [3];

	logic signed [31:0] self_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] vel_q [3];
	logic last_q;

	logic signed [SUM_W-1:0] sep_sum_q [3];
	logic signed [SUM_W-1:0] vel_sum_q [3];
	logic signed [SUM_W-1:0] pos_sum_q [3];
	logic [CNT_W-1:0] sep_cnt_q, ali_cnt_q, coh_cnt_q, rec_cnt_q;

	logic [2:0] step_q;
	logic [63:0] mul_q;
	logic [63:0] d2_q;
	logic [31:0] r2_q [3];
	logic in_sep_q, in_ali_q, in_coh_q;
	logic [1:0] wcode_q;

	logic [1:0] ax_q, grp_q;
	logic [SUM_W-1:0] dq_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic neg_q;
	logic [5:0] bit_q;
	logic signed [ACC_W-1:0] acc_q [3];

	logic res_valid_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;

	// operand select for the shared multiplier
	logic [1:0] mul_ax;
	logic signed [32:0] off_mul;
	logic [31:0] off_mag;
	logic [31:0] mul_a;
	logic [64:0] d2_sum;
	logic [1:0] prev_idx;

	always_comb begin
		mul_ax = (step_q < 3'd3) ? step_q[1:0] : 2'(step_q - 3'd3);
		off_mul = 33'(self_q[mul_ax]) - 33'(pos_q[mul_ax]);
		off_mag = off_mul[32] ? 32'(-off_mul) : off_mul[31:0];
		mul_a = (step_q < 3'd3) ? off_mag : {16'd0, radius_q[mul_ax]};
		d2_sum = {1'b0, d2_q} + {1'b0, mul_q};
		prev_idx = (step_q < 3'd4) ? 2'(step_q - 3'd1) : 2'(step_q - 3'd4);
	end

	// compare
	logic [31:0] d2_hi;
	logic d2_nz;
	assign d2_hi = d2_q[63:32];
	assign d2_nz = (d2_q != 64'd0);

	// weighted offset for one axis
	logic signed [32:0] off_acc;
	logic signed [36:0] off_w;
	always_comb begin
		off_acc = 33'(self_q[ax_q]) - 33'(pos_q[ax_q]);
		case (wcode_q)
			W10: off_w = (37'(off_acc) <<< 3) + (37'(off_acc) <<< 1);
			W5:  off_w = (37'(off_acc) <<< 2) + 37'(off_acc);
			W2:  off_w = 37'(off_acc) <<< 1;
			default: off_w = 37'(off_acc);
		endcase
	end

	// divider operand select
	logic signed [SUM_W-1:0] div_sum;
	logic [CNT_W-1:0] div_cnt;
	always_comb begin
		case (grp_q)
			GRP_SEP: begin
				div_sum = sep_sum_q[ax_q];
				div_cnt = sep_cnt_q;
			end
			GRP_ALI: begin
				div_sum = vel_sum_q[ax_q];
				div_cnt = ali_cnt_q;
			end
			default: begin
				div_sum = pos_sum_q[ax_q];
				div_cnt = coh_cnt_q;
			end
		endcase
	end

	logic [CNT_W:0] div_t;
	logic div_ge;
	assign div_t = {rem_q, dq_q[SUM_W-1]};
	assign div_ge = (div_t >= {1'b0, dvs_q});

	logic last_term;
	assign last_term = (grp_q == GRP_COH) && (ax_q == 2'd2);

	// final combine and clamp
	logic signed [ACC_W-1:0] fin [3];
	logic signed [31:0] sat [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fin[i] = acc_q[i] - ((coh_cnt_q != '0) ? ACC_W'(self_q[i]) : '0);
			if (fin[i] > ACC_W'(64'sd2147483647))
				sat[i] = 32'sh7fffffff;
			else if (fin[i] < -ACC_W'(64'sd2147483648))
				sat[i] = 32'sh80000000;
			else
				sat[i] = fin[i][31:0];
		end
	end

	logic rec_beat;
	assign rec_beat = rec.valid && rec.ready;
	assign rec.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			ax_q <= '0;
			grp_q <= '0;
			bit_q <= '0;
			sep_cnt_q <= '0;
			ali_cnt_q <= '0;
			coh_cnt_q <= '0;
			rec_cnt_q <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sep_sum_q[i] <= '0;
				vel_sum_q[i] <= '0;
				pos_sum_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			// ST_OUT handles its own handover of the output register
			if (res_valid_q && res.ready && state_q != ST_OUT)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (rec_beat) begin
						if (rec_cnt_q < CNT_W'(MAX_NEIGHBOURS)) begin
							rec_cnt_q <= rec_cnt_q + 1'b1;
							step_q <= '0;
							state_q <= ST_MUL;
						end else if (rec.last_one) begin
							grp_q <= GRP_SEP;
							ax_q <= '0;
							state_q <= ST_DLOAD;
						end
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd6)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					ax_q <= '0;
					if (d2_nz && d2_hi < r2_q[REG_SEP])
						sep_cnt_q <= sep_cnt_q + 1'b1;
					if (d2_nz && d2_hi < r2_q[REG_ALI])
						ali_cnt_q <= ali_cnt_q + 1'b1;
					if (d2_nz && d2_hi < r2_q[REG_COH])
						coh_cnt_q <= coh_cnt_q + 1'b1;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (in_sep_q)
						sep_sum_q[ax_q] <= sep_sum_q[ax_q] + SUM_W'(off_w);
					if (in_ali_q)
						vel_sum_q[ax_q] <= vel_sum_q[ax_q] + SUM_W'(vel_q[ax_q]);
					if (in_coh_q)
						pos_sum_q[ax_q] <= pos_sum_q[ax_q] + SUM_W'(pos_q[ax_q]);
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						grp_q <= GRP_SEP;
						state_q <= last_q ? ST_DLOAD : ST_IDLE;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				ST_DLOAD: begin
					if (div_cnt == '0) begin
						if (last_term) begin
							state_q <= ST_OUT;
						end else if (ax_q == 2'd2) begin
							ax_q <= '0;
							grp_q <= grp_q + 1'b1;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end else begin
						bit_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'(SUM_W - 1))
						state_q <= ST_DSUM;
				end
				ST_DSUM: begin
					acc_q[ax_q] <= acc_q[ax_q] +
						(neg_q ? -ACC_W'(signed'({1'b0, dq_q})) : ACC_W'(signed'({1'b0, dq_q})));
					if (last_term) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DLOAD;
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							grp_q <= grp_q + 1'b1;
						end else begin
							ax_q <= ax_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						sep_cnt_q <= '0;
						ali_cnt_q <= '0;
						coh_cnt_q <= '0;
						rec_cnt_q <= '0;
						for (int i = 0; i < 3; i++) begin
							sep_sum_q[i] <= '0;
							vel_sum_q[i] <= '0;
							pos_sum_q[i] <= '0;
							acc_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rec_beat) begin
			self_q[0] <= rec.self_x;
			self_q[1] <= rec.self_y;
			self_q[2] <= rec.self_z;
			pos_q[0] <= rec.other_px;
			pos_q[1] <= rec.other_py;
			pos_q[2] <= rec.other_pz;
			vel_q[0] <= rec.other_vx;
			vel_q[1] <= rec.other_vy;
			vel_q[2] <= rec.other_vz;
			last_q <= rec.last_one;
			d2_q <= '0;
		end
		if (state_q == ST_MUL) begin
			if (step_q < 3'd6)
				mul_q <= 64'(mul_a) * 64'(mul_a);
			// consume the previous product
			if (step_q >= 3'd1 && step_q <= 3'd3)
				d2_q <= d2_sum[64] ? '1 : d2_sum[63:0];
			else if (step_q >= 3'd4)
				r2_q[prev_idx] <= mul_q[31:0];
		end
		if (state_q == ST_CMP) begin
			in_sep_q <= d2_nz && (d2_hi < r2_q[REG_SEP]);
			in_ali_q <= d2_nz && (d2_hi < r2_q[REG_ALI]);
			in_coh_q <= d2_nz && (d2_hi < r2_q[REG_COH]);
			if (d2_hi < TIER10_SQ)
				wcode_q <= W10;
			else if (d2_hi < TIER5_SQ)
				wcode_q <= W5;
			else if (d2_hi < TIER2_SQ)
				wcode_q <= W2;
			else
				wcode_q <= W1;
		end
		if (state_q == ST_DLOAD) begin
			neg_q <= div_sum[SUM_W-1];
			dq_q <= div_sum[SUM_W-1] ? SUM_W'(-div_sum) : div_sum;
			rem_q <= '0;
			dvs_q <= div_cnt;
		end
		if (state_q == ST_DIV) begin
			// restoring divide, one quotient bit per cycle
			rem_q <= div_ge ? CNT_W'(div_t - {1'b0, dvs_q}) : div_t[CNT_W-1:0];
			dq_q <= {dq_q[SUM_W-2:0], div_ge};
		end
		if (state_q == ST_OUT && (!res_valid_q || res.ready)) begin
			res_x_q <= sat[0];
			res_y_q <= sat[1];
			res_z_q <= sat[2];
		end
	end

	assign res.valid = res_valid_q;
	assign res.accel_x = res_x_q;
	assign res.accel_y = res_y_q;
	assign res.accel_z = res_z_q;

	// register port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q[REG_SEP] <= SEP_RADIUS_RST;
			radius_q[REG_ALI] <= ALI_RADIUS_RST;
			radius_q[REG_COH] <= COH_RADIUS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SEP: radius_q[REG_SEP] <= pwdata[15:0];
				REG_ALI: radius_q[REG_ALI] <= pwdata[15:0];
				REG_COH: radius_q[REG_COH] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SEP: prdata = {16'd0, radius_q[REG_SEP]};
			REG_ALI: prdata = {16'd0, radius_q[REG_ALI]};
			REG_COH: prdata = {16'd0, radius_q[REG_COH]};
			default: prdata = 32'd0;
		endcase
	end
endmodule

>>> rtl/core/fsa_chk.sv
// Port-level checks for the flocking steering accumulator.
// Bound to flocking_steering_accumulator_top; no package use.
module fsa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rec_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_x,
	input logic [31:0] res_y,
	input logic [31:0] res_z
);
	// in reset: no result offered, input side idle and ready
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !res_valid && rec_ready)
		else $error("block not idle during reset");

	a_res_known: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !$isunknown({res_x, res_y, res_z}))
		else $error("result payload unknown while valid");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_x) && $stable(res_y) && $stable(res_z))
		else $error("result payload changed while stalled");
endmodule

bind flocking_steering_accumulator_top fsa_chk u_fsa_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rec_ready(rec.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_x(res.accel_x),
	.res_y(res.accel_y),
	.res_z(res.accel_z)
);
